>>> sv/ncc_pkg.sv
package ncc_pkg;

	localparam int PIXEL_BITS     = 8;
	localparam int CORR_FRAC_BITS = 15;

	localparam int PIX_W  = PIXEL_BITS;
	localparam int PR_W   = 2 * PIX_W;
	localparam int SUM_W  = PIX_W + 4;
	localparam int SQ_W   = 2 * PIX_W + 4;
	localparam int V_W    = 2 * PIX_W + 8;
	localparam int P_W    = 2 * V_W;
	localparam int M_W    = 16;
	localparam int R_W    = 2 * (V_W + CORR_FRAC_BITS + 1);
	localparam int T_W    = P_W + 2 * M_W + 2;
	localparam int CMP_W  = ((R_W > T_W) ? R_W : T_W) + 2;
	localparam int CORR_W = 16;

	localparam int ONE_INT = ((1 << CORR_FRAC_BITS) > 32767) ? 32767 : (1 << CORR_FRAC_BITS);
	localparam logic signed [CORR_W-1:0] CORR_ONE = CORR_W'(ONE_INT);
	localparam logic signed [CORR_W-1:0] CORR_MAX = 16'sh7fff;
	localparam logic signed [CORR_W-1:0] CORR_MIN = 16'sh8000;
	localparam logic [M_W-1:0] M_CAP = M_W'(32768);

	localparam int LANE_LAT = M_W + 4;
	localparam int PIPE_LAT = LANE_LAT + 6;

	localparam int ADDR_W = 3;
	localparam logic REG_IDX_THRESHOLD = 1'b0;
	localparam logic [15:0] THR_RESET = 16'h4000;

	typedef struct packed {
		logic [23:0] template_row_0;
		logic [23:0] template_row_1;
		logic [23:0] template_row_2;
		logic [39:0] search_row_0;
		logic [39:0] search_row_1;
		logic [39:0] search_row_2;
		logic [39:0] search_row_3;
		logic [39:0] search_row_4;
	} ncc_in_t;

	typedef struct packed {
		logic signed [15:0] best_corr;
		logic               match_ok;
	} ncc_out_t;

	typedef struct packed {
		logic [SUM_W-1:0] sa;
		logic [SUM_W-1:0] sb;
		logic [SQ_W-1:0]  saa;
		logic [SQ_W-1:0]  sbb;
		logic [SQ_W-1:0]  sab;
	} ncc_sums_t;

	function automatic logic [PIX_W-1:0] pix(input logic [63:0] row, input int col);
		if (col * PIX_W >= 64) begin
			return '0;
		end
		return PIX_W'(row >> (col * PIX_W));
	endfunction

	function automatic logic signed [CORR_W-1:0] smax(input logic signed [CORR_W-1:0] a,
			input logic signed [CORR_W-1:0] b);
		return (b > a) ? b : a;
	endfunction

endpackage

>>> sv/ncc_lane.sv
module ncc_lane import ncc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  ncc_sums_t                sums,
	output logic                     out_valid,
	output logic signed [CORR_W-1:0] coef
);

	logic [V_W-1:0] saa9, sasq, p1, p2;
	logic [V_W-1:0] sbb9, sbsq;

	logic             v_s1, neg_s1;
	logic [V_W-1:0]   va_s1, vb_s1, mag_s1;
	logic             v_s2, neg_s2, flat_s2;
	logic [P_W-1:0]   p_s2;
	logic [2*V_W-1:0] msq_s2;

	logic                    srch_v_s    [M_W+1];
	logic signed [CMP_W-1:0] srch_e_s    [M_W+1];
	logic signed [CMP_W-1:0] srch_q_s    [M_W+1];
	logic [P_W-1:0]          srch_p_s    [M_W+1];
	logic [M_W-1:0]          srch_m_s    [M_W+1];
	logic                    srch_flat_s [M_W+1];
	logic                    srch_neg_s  [M_W+1];

	logic signed [CMP_W-1:0] t_term [M_W];
	logic [M_W-1:0]          take;
	logic [M_W-1:0]          m_cap;
	logic signed [CORR_W:0]  m_ext;

	always_comb begin
		saa9 = (V_W'(sums.saa) << 3) + V_W'(sums.saa);
		sasq = V_W'(sums.sa) * V_W'(sums.sa);
		sbb9 = (V_W'(sums.sbb) << 3) + V_W'(sums.sbb);
		sbsq = V_W'(sums.sb) * V_W'(sums.sb);
		p1   = (V_W'(sums.sab) << 3) + V_W'(sums.sab);
		p2   = V_W'(sums.sa) * V_W'(sums.sb);
	end

	always_comb begin
		for (int j = 0; j < M_W; j++) begin
			t_term[j] = (srch_q_s[j] <<< (M_W + 1 - j))
				+ ($signed(CMP_W'(srch_p_s[j])) <<< (2 * (M_W - 1 - j) + 2));
			take[j] = srch_e_s[j] >= t_term[j];
		end
	end

	always_comb begin
		m_cap = (srch_m_s[M_W] > M_CAP) ? M_CAP : srch_m_s[M_W];
		m_ext = $signed({1'b0, m_cap});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
			for (int j = 0; j <= M_W; j++) begin
				srch_v_s[j] <= 1'b0;
			end
		end else begin
			v_s1        <= in_valid;
			v_s2        <= v_s1;
			srch_v_s[0] <= v_s2;
			for (int j = 0; j < M_W; j++) begin
				srch_v_s[j+1] <= srch_v_s[j];
			end
			out_valid <= srch_v_s[M_W];
		end
	end

	always_ff @(posedge clk) begin
		va_s1  <= saa9 - sasq;
		vb_s1  <= sbb9 - sbsq;
		neg_s1 <= p2 > p1;
		mag_s1 <= (p2 > p1) ? (p2 - p1) : (p1 - p2);

		p_s2    <= P_W'(va_s1) * P_W'(vb_s1);
		msq_s2  <= (2*V_W)'(mag_s1) * (2*V_W)'(mag_s1);
		flat_s2 <= (va_s1 == '0) || (vb_s1 == '0);
		neg_s2  <= neg_s1;

		srch_e_s[0]    <= $signed((CMP_W'(msq_s2) << (2 * CORR_FRAC_BITS + 2)) - CMP_W'(p_s2));
		srch_q_s[0]    <= -$signed(CMP_W'(p_s2));
		srch_p_s[0]    <= p_s2;
		srch_m_s[0]    <= '0;
		srch_flat_s[0] <= flat_s2;
		srch_neg_s[0]  <= neg_s2;

		for (int j = 0; j < M_W; j++) begin
			srch_e_s[j+1] <= take[j] ? (srch_e_s[j] - t_term[j]) : srch_e_s[j];
			srch_q_s[j+1] <= take[j]
				? (srch_q_s[j] + ($signed(CMP_W'(srch_p_s[j])) <<< (M_W - j)))
				: srch_q_s[j];
			srch_m_s[j+1] <= take[j]
				? (srch_m_s[j] | (M_W'(1) << (M_W - 1 - j)))
				: srch_m_s[j];
			srch_p_s[j+1]    <= srch_p_s[j];
			srch_flat_s[j+1] <= srch_flat_s[j];
			srch_neg_s[j+1]  <= srch_neg_s[j];
		end

		if (srch_flat_s[M_W]) begin
			coef <= CORR_ONE;
		end else if (srch_neg_s[M_W]) begin
			coef <= CORR_W'(-m_ext);
		end else if (m_cap > M_W'(CORR_MAX)) begin
			coef <= CORR_MAX;
		end else begin
			coef <= CORR_W'(m_cap);
		end
	end

endmodule

>>> sv/ncc_template_match_3x3_in_5x5.sv
// Normalized cross-correlation template match, 3x3 template in a 5x5 patch.
// Input: pulse start with the template rows and search rows on item; the
//   transaction is taken at the clock edge where start is high and busy is
//   low. busy is high while in reset and until the first clock edge after
//   reset is released; a new transaction may be issued on every cycle after that.
// Output: done is high for exactly one cycle with best_corr and match_ok on
//   result. The receiver cannot stall the block, so results are dropped if
//   not captured in that cycle.
// Pipeline: two stages form products and window sums, twenty stages per
//   position compute the coefficient (sixteen of them are the bit-serial
//   square-root search), and four stages take the maximum and compare
//   against the threshold. Throughput is one transaction per cycle.
// Configuration: APB register 0 (byte address 0) holds match_threshold,
//   signed Q1.15, reset value 0x4000. Write only while no transaction is in
//   flight. pready is always high.
// Reset: asynchronous, active low; clears all valid bits and loads the
//   threshold reset value.
module ncc_template_match_3x3_in_5x5 import ncc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ncc_in_t           item,
	output logic              done,
	output ncc_out_t          result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [63:0]      trow [3];
	logic [63:0]      srow [5];
	logic [PIX_W-1:0] tpix [9];
	logic [PIX_W-1:0] spix [25];

	logic             busy_q;
	logic [15:0]      thr_q;

	logic             v_s1;
	logic [PIX_W-1:0] tpix_s1 [9];
	logic [PIX_W-1:0] spix_s1 [25];
	logic [PR_W-1:0]  aa_s1   [9];
	logic [PR_W-1:0]  bb_s1   [25];
	logic [PR_W-1:0]  ab_s1   [9][9];

	ncc_sums_t        sums_d  [9];
	logic             v_s2;
	ncc_sums_t        sums_s2 [9];

	logic [8:0]                lane_v;
	logic signed [CORR_W-1:0]  coef [9];

	logic                      v_t1, v_t2, v_t3;
	logic signed [CORR_W-1:0]  mx_t1 [4];
	logic signed [CORR_W-1:0]  c8_t1;
	logic signed [CORR_W-1:0]  mx_t2 [2];
	logic signed [CORR_W-1:0]  c8_t2;
	logic signed [CORR_W-1:0]  best_t3;

	logic                      done_q;
	ncc_out_t                  result_q;

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = result_q;
	assign pready = 1'b1;
	assign prdata = (paddr[ADDR_W-1] == REG_IDX_THRESHOLD) ? {16'b0, thr_q} : 32'b0;

	always_comb begin
		trow[0] = 64'(item.template_row_0);
		trow[1] = 64'(item.template_row_1);
		trow[2] = 64'(item.template_row_2);
		srow[0] = 64'(item.search_row_0);
		srow[1] = 64'(item.search_row_1);
		srow[2] = 64'(item.search_row_2);
		srow[3] = 64'(item.search_row_3);
		srow[4] = 64'(item.search_row_4);
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				tpix[r*3+c] = pix(trow[r], c);
			end
		end
		for (int r = 0; r < 5; r++) begin
			for (int c = 0; c < 5; c++) begin
				spix[r*5+c] = pix(srow[r], c);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			thr_q  <= THR_RESET;
		end else begin
			busy_q <= 1'b0;
			if (psel && penable && pwrite && (paddr[ADDR_W-1] == REG_IDX_THRESHOLD)) begin
				thr_q <= pwdata[15:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_t1   <= 1'b0;
			v_t2   <= 1'b0;
			v_t3   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start && !busy_q;
			v_s2   <= v_s1;
			v_t1   <= &lane_v;
			v_t2   <= v_t1;
			v_t3   <= v_t2;
			done_q <= v_t3;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 9; k++) begin
			tpix_s1[k] <= tpix[k];
			aa_s1[k]   <= PR_W'(tpix[k]) * PR_W'(tpix[k]);
		end
		for (int k = 0; k < 25; k++) begin
			spix_s1[k] <= spix[k];
			bb_s1[k]   <= PR_W'(spix[k]) * PR_W'(spix[k]);
		end
		for (int py = 0; py < 3; py++) begin
			for (int px = 0; px < 3; px++) begin
				for (int r = 0; r < 3; r++) begin
					for (int c = 0; c < 3; c++) begin
						ab_s1[py*3+px][r*3+c] <= PR_W'(tpix[r*3+c])
							* PR_W'(spix[(py+r)*5+px+c]);
					end
				end
			end
		end
	end

	always_comb begin
		logic [SUM_W-1:0] sa;
		logic [SQ_W-1:0]  saa;
		sa  = '0;
		saa = '0;
		for (int k = 0; k < 9; k++) begin
			sa  = sa + SUM_W'(tpix_s1[k]);
			saa = saa + SQ_W'(aa_s1[k]);
		end
		for (int py = 0; py < 3; py++) begin
			for (int px = 0; px < 3; px++) begin
				sums_d[py*3+px].sa  = sa;
				sums_d[py*3+px].saa = saa;
				sums_d[py*3+px].sb  = '0;
				sums_d[py*3+px].sbb = '0;
				sums_d[py*3+px].sab = '0;
				for (int r = 0; r < 3; r++) begin
					for (int c = 0; c < 3; c++) begin
						sums_d[py*3+px].sb = sums_d[py*3+px].sb
							+ SUM_W'(spix_s1[(py+r)*5+px+c]);
						sums_d[py*3+px].sbb = sums_d[py*3+px].sbb
							+ SQ_W'(bb_s1[(py+r)*5+px+c]);
						sums_d[py*3+px].sab = sums_d[py*3+px].sab
							+ SQ_W'(ab_s1[py*3+px][r*3+c]);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int p = 0; p < 9; p++) begin
			sums_s2[p] <= sums_d[p];
		end
	end

	for (genvar p = 0; p < 9; p++) begin : g_lane
		ncc_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v_s2),
			.sums      (sums_s2[p]),
			.out_valid (lane_v[p]),
			.coef      (coef[p])
		);
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			mx_t1[k] <= smax(coef[2*k], coef[2*k+1]);
		end
		c8_t1    <= coef[8];
		mx_t2[0] <= smax(mx_t1[0], mx_t1[1]);
		mx_t2[1] <= smax(mx_t1[2], mx_t1[3]);
		c8_t2    <= c8_t1;
		best_t3  <= smax(smax(mx_t2[0], mx_t2[1]), c8_t2);
		result_q.best_corr <= best_t3;
		result_q.match_ok  <= best_t3 > $signed(thr_q);
	end

endmodule

>>> sv/ncc_checker.sv
module ncc_checker import ncc_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input logic     done,
	input ncc_out_t result
);

	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_LAT))
		else $error("result without an accepted transaction");

	a_source_has_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##PIPE_LAT done)
		else $error("accepted transaction produced no result");

	a_match_not_min: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.match_ok) |-> (result.best_corr != CORR_MIN))
		else $error("match flagged on minimum correlation");

endmodule

bind ncc_template_match_3x3_in_5x5 ncc_checker u_ncc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

>>> tb/ncc_match_checker.sv
`timescale 1ns / 100ps

module ncc_match_checker import ncc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  ncc_in_t           item,
	input  logic              done,
	input  ncc_out_t          result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	input  logic              pready,
	output int                pending,
	output int                errors
);

	localparam logic [ADDR_W-1:0] ADDR_THRESHOLD = ADDR_W'(REG_IDX_THRESHOLD);

	logic signed [15:0] threshold;
	ncc_out_t           best_q[$];

	initial errors = 0;
	assign pending = best_q.size();

	task automatic report(input string what, input int got, input int want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	function automatic logic signed [15:0] corr_at(longint sa, longint saa, longint sb,
			longint sbb, longint sab);
		longint va, vb, nab, mag;
		logic [127:0] prod, rhs, lhs, odd;
		int lo, hi, mid;
		va = 9 * saa - sa * sa;
		vb = 9 * sbb - sb * sb;
		if (va == 0 || vb == 0) begin
			return CORR_ONE;
		end
		nab = 9 * sab - sa * sb;
		mag = (nab < 0) ? -nab : nab;
		prod = 128'(va) * 128'(vb);
		rhs = 128'(mag) << (CORR_FRAC_BITS + 1);
		rhs = rhs * rhs;
		lo = 0;
		hi = 32768;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			odd = 128'(2 * mid - 1);
			lhs = odd * odd * prod;
			if (lhs <= rhs) lo = mid;
			else hi = mid - 1;
		end
		if (nab < 0) begin
			return 16'(-lo);
		end
		return (lo > 32767) ? CORR_MAX : 16'(lo);
	endfunction

	function automatic ncc_out_t predict_best(ncc_in_t x, logic signed [15:0] thr);
		logic [23:0] trow[3];
		logic [39:0] srow[5];
		longint t[3][3], s[5][5];
		longint sa, saa, sb, sbb, sab;
		logic signed [15:0] v, best;
		ncc_out_t o;
		trow = '{x.template_row_0, x.template_row_1, x.template_row_2};
		srow = '{x.search_row_0, x.search_row_1, x.search_row_2, x.search_row_3,
			x.search_row_4};
		sa = 0;
		saa = 0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				t[r][c] = longint'(trow[r][8*c +: 8]);
				sa += t[r][c];
				saa += t[r][c] * t[r][c];
			end
		end
		for (int r = 0; r < 5; r++) begin
			for (int c = 0; c < 5; c++) begin
				s[r][c] = longint'(srow[r][8*c +: 8]);
			end
		end
		best = CORR_MIN;
		for (int py = 0; py < 3; py++) begin
			for (int px = 0; px < 3; px++) begin
				sb = 0;
				sbb = 0;
				sab = 0;
				for (int r = 0; r < 3; r++) begin
					for (int c = 0; c < 3; c++) begin
						sb += s[py+r][px+c];
						sbb += s[py+r][px+c] * s[py+r][px+c];
						sab += t[r][c] * s[py+r][px+c];
					end
				end
				v = corr_at(sa, saa, sb, sbb, sab);
				if ((py == 0 && px == 0) || v > best) best = v;
			end
		end
		o.best_corr = best;
		o.match_ok = best > thr;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ncc_out_t want;
		if (!arst_n) begin
			threshold <= THR_RESET;
		end else begin
			if (psel && penable && pwrite && pready && paddr == ADDR_THRESHOLD) begin
				threshold <= pwdata[15:0];
			end
			if (start && !busy) begin
				best_q = {best_q, predict_best(item, threshold)};
			end
			if (done) begin
				if (best_q.size() == 0) begin
					report("result transaction count", 1, 0);
				end else begin
					want = best_q.pop_front();
					if (result.best_corr !== want.best_corr)
						report("best_corr", int'(result.best_corr), int'(want.best_corr));
					if (result.match_ok !== want.match_ok)
						report("match_ok", int'(result.match_ok), int'(want.match_ok));
				end
			end
		end
	end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import ncc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	typedef enum int {
		PK_RANDOM,
		PK_COPY,
		PK_INVERTED,
		PK_FLAT_TEMPLATE,
		PK_FLAT_SEARCH,
		PK_NARROW,
		PK_CONSTANT
	} patch_kind_t;

	logic              clk = 0;
	logic              arst_n = 0;
	logic              start = 0;
	logic              busy;
	ncc_in_t           item = '0;
	logic              done;
	ncc_out_t          result;
	logic              psel = 0;
	logic              penable = 0;
	logic              pwrite = 0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	int                pending;
	int                errors;
	int                cycles = 0;

	always #5 clk = ~clk;

	ncc_template_match_3x3_in_5x5 uut (.*);

	ncc_match_checker chk (.*);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic ncc_in_t pack_patch(logic [7:0] t[3][3], logic [7:0] s[5][5]);
		ncc_in_t x;
		logic [23:0] tr[3];
		logic [39:0] sr[5];
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++) tr[r][8*c +: 8] = t[r][c];
		for (int r = 0; r < 5; r++)
			for (int c = 0; c < 5; c++) sr[r][8*c +: 8] = s[r][c];
		x.template_row_0 = tr[0];
		x.template_row_1 = tr[1];
		x.template_row_2 = tr[2];
		x.search_row_0 = sr[0];
		x.search_row_1 = sr[1];
		x.search_row_2 = sr[2];
		x.search_row_3 = sr[3];
		x.search_row_4 = sr[4];
		return x;
	endfunction

	function automatic ncc_in_t make_patch(patch_kind_t kind, int k0, int k1);
		logic [7:0] t[3][3], s[5][5];
		int py, px, off, v, lo;
		lo = $urandom_range(0, 250);
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++) t[r][c] = 8'($urandom);
		for (int r = 0; r < 5; r++)
			for (int c = 0; c < 5; c++) s[r][c] = 8'($urandom);
		py = $urandom_range(0, 2);
		px = $urandom_range(0, 2);
		off = $urandom_range(0, 40) - 20;
		case (kind)
			PK_COPY, PK_INVERTED: begin
				for (int r = 0; r < 3; r++)
					for (int c = 0; c < 3; c++) begin
						v = (kind == PK_COPY) ? t[r][c] + off : 255 - t[r][c];
						if ($urandom_range(0, 3) == 0) v += $urandom_range(0, 4) - 2;
						s[py+r][px+c] = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
					end
			end
			PK_FLAT_TEMPLATE: foreach (t[r, c]) t[r][c] = 8'(k0);
			PK_FLAT_SEARCH: foreach (s[r, c]) s[r][c] = 8'(k0);
			PK_NARROW: begin
				foreach (t[r, c]) t[r][c] = 8'(lo + $urandom_range(0, 5));
				foreach (s[r, c]) s[r][c] = 8'(lo + $urandom_range(0, 5));
			end
			PK_CONSTANT: begin
				foreach (t[r, c]) t[r][c] = 8'(k0);
				foreach (s[r, c]) s[r][c] = 8'(k1);
			end
			default: ;
		endcase
		return pack_patch(t, s);
	endfunction

	task automatic send(input ncc_in_t x, input bit idle_ok);
		start <= 1'b1;
		item <= x;
		do @(posedge clk); while (busy);
		if (idle_ok && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (PIPE_LAT + 4) @(posedge clk);
	endtask

	task automatic write_threshold(input logic signed [15:0] thr);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(REG_IDX_THRESHOLD);
		pwdata <= {{16{thr[15]}}, thr};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic signed [15:0] thresholds[5];
		int sel;
		patch_kind_t kind;
		thresholds = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff, 16'sh0000};
		thresholds[4] = 16'($urandom);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send('0, 1'b0);
		send('1, 1'b0);
		send(make_patch(PK_CONSTANT, 0, 255), 1'b0);
		send(make_patch(PK_CONSTANT, 255, 0), 1'b0);
		send(make_patch(PK_FLAT_TEMPLATE, 0, 0), 1'b1);
		send(make_patch(PK_FLAT_TEMPLATE, 255, 0), 1'b0);
		send(make_patch(PK_FLAT_SEARCH, 0, 0), 1'b1);
		send(make_patch(PK_FLAT_SEARCH, 255, 0), 1'b0);
		send(make_patch(PK_FLAT_SEARCH, 77, 0), 1'b0);
		for (int i = 0; i < 4; i++) send(make_patch(PK_COPY, 0, 0), 1'b1);
		for (int i = 0; i < 4; i++) send(make_patch(PK_INVERTED, 0, 0), 1'b1);
		for (int i = 0; i < 3; i++) send(make_patch(PK_NARROW, 0, 0), 1'b0);
		for (int i = 0; i < 3; i++) send(make_patch(PK_RANDOM, 0, 0), 1'b1);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			write_threshold(thresholds[ph]);
			for (int i = 0; i < 160; i++) begin
				sel = $urandom_range(0, 9);
				kind = (sel > 6) ? PK_COPY : patch_kind_t'(sel);
				send(make_patch(kind, $urandom_range(0, 255), $urandom_range(0, 255)),
					ph < 4 || i < 60);
			end
			drain();
		end

		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
